// File: sv/icpe_pkg.sv
`default_nettype none

package icpe_pkg;

    localparam int unsigned CHANNELS   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_ALPHA  = 3'd5;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_GRAY = 2'd1;
    localparam logic [1:0] MODE_TINT = 2'd2;

    localparam logic [1:0] RST_EFFECT_MODE = MODE_NONE;
    localparam logic [7:0] RST_AMOUNT      = 8'd255;
    localparam logic [7:0] RST_TINT_RED    = 8'd144;
    localparam logic [7:0] RST_TINT_GREEN  = 8'd128;
    localparam logic [7:0] RST_TINT_BLUE   = 8'd248;
    localparam logic       RST_HALF_ALPHA  = 1'b0;

    localparam logic [7:0] AMOUNT_FULL = 8'd255;
    localparam logic [7:0] GRAY_MID    = 8'd128;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_pixel_out;

    typedef logic [CHANNELS-1:0][7:0] t_chan8;
    typedef logic [CHANNELS-1:0][15:0] t_chan16;

endpackage

`default_nettype wire

// File: sv/icon_pixel_effect_top.sv
// Per-pixel color effect on non-premultiplied ARGB8888: pass-through, blend toward
// luma, or colorize through a tint color, with optional alpha halving. One pixel
// may be started every clock (o_busy stays low). Its result is on o_result with
// o_valid high for one cycle, after the four register stages (luma, tint map,
// blend products, sum and select). The receiver cannot stall the block.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata and must only
// change while no pixel is in flight.
`default_nettype none

module icon_pixel_effect_top
    import icpe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_pixel_in             i_pixel,
    output logic                       o_valid,
    output t_pixel_out                 o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [1:0] r_mode;
    logic [7:0] r_amount;
    t_chan8     r_tint;
    logic       r_half_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= RST_EFFECT_MODE;
            r_amount     <= RST_AMOUNT;
            r_tint[0]    <= RST_TINT_RED;
            r_tint[1]    <= RST_TINT_GREEN;
            r_tint[2]    <= RST_TINT_BLUE;
            r_half_alpha <= RST_HALF_ALPHA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EFFECT_MODE: r_mode       <= i_cfg_wdata[1:0];
                CFG_AMOUNT:      r_amount     <= i_cfg_wdata[7:0];
                CFG_TINT_RED:    r_tint[0]    <= i_cfg_wdata[7:0];
                CFG_TINT_GREEN:  r_tint[1]    <= i_cfg_wdata[7:0];
                CFG_TINT_BLUE:   r_tint[2]    <= i_cfg_wdata[7:0];
                CFG_HALF_ALPHA:  r_half_alpha <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // valid chain
    logic r1_vld, r2_vld, r3_vld, r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r1_vld    <= accept;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r_out_vld <= r3_vld;
        end
    end

    // stage 1: luma
    logic [12:0] n1_sum;
    t_chan8      r1_pix;
    logic [7:0]  r1_alpha;
    logic [7:0]  r1_gray;

    assign n1_sum = 13'({i_pixel.in_red, 3'b000}) + 13'({i_pixel.in_red, 1'b0})
                  + 13'(i_pixel.in_red) + 13'({i_pixel.in_green, 4'b0000})
                  + 13'({i_pixel.in_blue, 2'b00}) + 13'(i_pixel.in_blue);

    always_ff @(posedge i_clk) begin
        r1_gray  <= n1_sum[12:5];
        r1_pix   <= {i_pixel.in_blue, i_pixel.in_green, i_pixel.in_red};
        r1_alpha <= i_pixel.in_alpha;
    end

    // stage 2: target value per channel
    t_chan8     n2_x;
    t_chan8     r2_x;
    t_chan8     r2_pix;
    logic [7:0] r2_gray;
    logic [7:0] r2_alpha;

    always_comb begin
        logic [15:0] lo_prod;
        logic [15:0] hi_prod;
        logic [16:0] hi_sum;
        for (int i = 0; i < CHANNELS; i++) begin
            lo_prod = 16'(r_tint[i] * r1_gray);
            hi_prod = 16'(r1_gray[6:0] * (9'd256 - {1'b0, r_tint[i]}));
            hi_sum  = {1'b0, hi_prod} + {2'b00, r_tint[i], 7'b0} - 17'd128;
            if (r_mode == MODE_GRAY) begin
                n2_x[i] = r1_gray;
            end else if (r1_gray < GRAY_MID) begin
                n2_x[i] = lo_prod[14:7];
            end else if (r1_gray > GRAY_MID) begin
                n2_x[i] = hi_sum[14:7];
            end else begin
                n2_x[i] = r_tint[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_x     <= n2_x;
        r2_pix   <= r1_pix;
        r2_gray  <= r1_gray;
        r2_alpha <= r1_alpha;
    end

    // stage 3: blend products
    t_chan16    r3_pa;
    t_chan16    r3_pc;
    t_chan8     r3_pix;
    logic [7:0] r3_gray;
    logic [7:0] r3_alpha;
    logic [7:0] amount_inv;

    assign amount_inv = AMOUNT_FULL - r_amount;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            r3_pa[i] <= 16'(r_amount * r2_x[i]);
            r3_pc[i] <= 16'(amount_inv * r2_pix[i]);
        end
        r3_pix   <= r2_pix;
        r3_gray  <= r2_gray;
        r3_alpha <= r2_alpha;
    end

    // stage 4: sum and select
    t_chan8     n4_chan;
    logic [7:0] n4_alpha;
    t_chan8     r_out_chan;
    logic [7:0] r_out_alpha;

    always_comb begin
        logic [16:0] mix_sum;
        for (int i = 0; i < CHANNELS; i++) begin
            mix_sum = {1'b0, r3_pa[i]} + {1'b0, r3_pc[i]};
            priority if (r_amount == 8'd0
                         || (r_mode != MODE_GRAY && r_mode != MODE_TINT)) begin
                n4_chan[i] = r3_pix[i];
            end else if (r_mode == MODE_GRAY && r_amount == AMOUNT_FULL) begin
                n4_chan[i] = r3_gray;
            end else begin
                n4_chan[i] = mix_sum[15:8];
            end
        end
        n4_alpha = r_half_alpha ? {1'b0, r3_alpha[7:1]} : r3_alpha;
    end

    always_ff @(posedge i_clk) begin
        r_out_chan  <= n4_chan;
        r_out_alpha <= n4_alpha;
    end

    assign o_valid            = r_out_vld;
    assign o_result.out_red   = r_out_chan[0];
    assign o_result.out_green = r_out_chan[1];
    assign o_result.out_blue  = r_out_chan[2];
    assign o_result.out_alpha = r_out_alpha;

endmodule

`default_nettype wire

// File: sv/icpe_checker.sv
`default_nettype none

module icpe_checker
    import icpe_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_valid,
    input wire t_pixel_out o_result
);

    // every accepted word comes out as a result with o_valid high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_valid)
        else $error("accepted word did not produce a result");

    // no result without an accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 4))
        else $error("result without accepted word");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised on a stall-free pipeline");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_result))
        else $error("unknown result word");

endmodule

bind icon_pixel_effect_top icpe_checker u_icpe_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
